>>> hw/rtl/bpoe_pkg.sv
`timescale 1ns / 1ps
package bpoe_pkg;
  localparam int MAX_SITES = 18;
  localparam int MAX_OPS = 24;
  localparam int MAP_DEPTH = 1 << MAX_SITES;
  localparam int PERM_DEPTH = MAX_OPS * MAX_SITES;
  localparam int PERM_AW = $clog2(PERM_DEPTH);
  localparam int NUM_W = MAX_SITES + 1;
  localparam int OPS_W = $clog2(MAX_OPS + 1);

  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_NEXT = 2'd1;
  localparam logic [1:0] REQ_RESTART = 2'd2;
  localparam logic [1:0] REQ_RESERVED = 2'd3;

  localparam logic CFG_ATOM_COUNT = 1'b0;
  localparam logic CFG_GROUP_ORDER = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] op_slot;
    logic [4:0] source_site;
    logic [4:0] dest_site;
  } in_item_t;

  typedef struct packed {
    logic [18:0] orbit_number;
    logic [17:0] pattern;
    logic [4:0]  image_count;
    logic        is_representative;
    logic        done_res;
    logic        last;
  } out_item_t;
endpackage

>>> hw/rtl/bit_pattern_orbit_enumerator_top.sv
`timescale 1ns / 1ps
// channel | signals                               | transfer
// in      | start, busy, in_item                  | at start && !busy
// out     | out_strobe, out_item                  | a strobe per result, no stall
// cfg     | cfg_valid, cfg_ready, cfg_index/data  | at cfg_valid && cfg_ready, idle only
// reset and a restart clear the visited bitmap one entry a cycle, all 2^MAX_SITES
// entries with busy high; a load or an unknown request ends at its accept edge
// a next-orbit request reads then checks each bitmap entry scanned (S_SCAN_RD,
// S_SCAN_CHK), then per permutation reads and accumulates over all MAX_SITES
// sites (S_PERM_RD, S_PERM_ACC), compares stored members in S_DEDUPE up to a match
// or list end, then emits through S_EMIT_REP and S_EMIT_MEM with the last
// result; the receiver cannot stall, and cfg_ready is low while busy
module bit_pattern_orbit_enumerator_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bpoe_pkg::in_item_t in_item,
  output logic               out_strobe,
  output bpoe_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [4:0]         cfg_index,
  input  logic [4:0]         cfg_data
);
  import bpoe_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_PERM_RD, S_PERM_ACC,
    S_DEDUPE, S_EMIT_REP, S_EMIT_MEM, S_DONE
  } state_t;

  state_t state_r;
  logic [4:0] atom_r, group_r;
  logic [NUM_W-1:0] scan_r, orbit_r;
  logic [MAX_SITES-1:0] clr_r;
  logic [MAX_SITES-1:0] rep_r, img_r;
  logic [4:0] site_r, op_r, cnt_r, k_r, emitted_r;
  logic [MAX_SITES-1:0] members_r [MAX_OPS];
  logic [MAX_SITES-1:0] hold_pat_r;
  logic hold_rep_r;

  logic [4:0] eff_n;
  logic [OPS_W-1:0] eff_ops;
  logic [NUM_W-1:0] limit;
  assign eff_n = (atom_r > 5'(MAX_SITES)) ? 5'(MAX_SITES) : atom_r;
  assign eff_ops = (group_r > 5'(MAX_OPS)) ? OPS_W'(MAX_OPS) : OPS_W'(group_r);
  assign limit = NUM_W'(1) << eff_n;

  // visited bitmap
  logic vm_we, vm_wd, vm_rd;
  logic [MAX_SITES-1:0] vm_wa, vm_ra;
  bpoe_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_visited (
    .clk(clk), .we(vm_we), .waddr(vm_wa), .wdata(vm_wd),
    .raddr(vm_ra), .rdata(vm_rd));

  // permutation table
  logic pt_we;
  logic [PERM_AW-1:0] pt_wa, pt_ra;
  logic [4:0] pt_rd;
  bpoe_ram #(.WIDTH(5), .DEPTH(PERM_DEPTH)) u_perm (
    .clk(clk), .we(pt_we), .waddr(pt_wa), .wdata(in_item.dest_site),
    .raddr(pt_ra), .rdata(pt_rd));

  logic accept;
  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign cfg_ready = (state_r == S_IDLE);

  assign pt_we = accept && in_item.req_type == REQ_LOAD &&
                 in_item.op_slot < 5'(MAX_OPS) && in_item.source_site < 5'(MAX_SITES);
  assign pt_wa = PERM_AW'(in_item.op_slot * MAX_SITES + in_item.source_site);
  assign pt_ra = PERM_AW'(op_r * MAX_SITES + site_r);
  assign vm_ra = scan_r[MAX_SITES-1:0];

  logic seen, new_img;
  assign seen = (k_r < cnt_r) && (members_r[k_r] == img_r);
  assign new_img = (k_r >= cnt_r);

  always_comb begin
    vm_we = 1'b0;
    vm_wa = clr_r;
    vm_wd = 1'b0;
    if (state_r == S_CLEAR) begin
      vm_we = 1'b1;
    end else if (state_r == S_DEDUPE && new_img) begin
      vm_we = 1'b1;
      vm_wa = img_r;
      vm_wd = 1'b1;
    end
  end

  // next member to emit: skip copies of the representative
  logic mem_skip, emit_end;
  assign mem_skip = (members_r[k_r] == rep_r);
  assign emit_end = (k_r >= cnt_r) || (emitted_r == 5'(MAX_OPS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      atom_r <= 5'd18;
      group_r <= '0;
      scan_r <= '0;
      orbit_r <= '0;
      cnt_r <= '0;
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 5'(CFG_ATOM_COUNT)) atom_r <= cfg_data;
        else if (cfg_index == 5'(CFG_GROUP_ORDER)) group_r <= cfg_data;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (&clr_r) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            if (in_item.req_type == REQ_NEXT) begin
              state_r <= S_SCAN_RD;
            end else if (in_item.req_type == REQ_RESTART) begin
              scan_r <= '0;
              orbit_r <= '0;
              cnt_r <= '0;
              clr_r <= '0;
              state_r <= S_CLEAR;
            end
          end
        end
        S_SCAN_RD: begin
          if (scan_r >= limit) state_r <= S_DONE;
          else state_r <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (vm_rd) begin
            scan_r <= scan_r + 1'b1;
            state_r <= S_SCAN_RD;
          end else begin
            rep_r <= scan_r[MAX_SITES-1:0];
            scan_r <= scan_r + 1'b1;
            orbit_r <= orbit_r + 1'b1;
            cnt_r <= '0;
            op_r <= '0;
            site_r <= '0;
            img_r <= '0;
            state_r <= (eff_ops == '0) ? S_EMIT_REP : S_PERM_RD;
          end
        end
        S_PERM_RD: begin
          state_r <= S_PERM_ACC;
        end
        S_PERM_ACC: begin
          if (rep_r[site_r] && pt_rd < eff_n && site_r < eff_n)
            img_r <= img_r | (MAX_SITES'(1) << pt_rd);
          if (site_r == 5'(MAX_SITES - 1)) begin
            k_r <= '0;
            state_r <= S_DEDUPE;
          end else begin
            site_r <= site_r + 1'b1;
            state_r <= S_PERM_RD;
          end
        end
        S_DEDUPE: begin
          if (seen || new_img) begin
            if (new_img) begin
              members_r[cnt_r] <= img_r;
              cnt_r <= cnt_r + 1'b1;
            end
            site_r <= '0;
            img_r <= '0;
            if (OPS_W'(op_r) + 1'b1 == eff_ops) begin
              state_r <= S_EMIT_REP;
            end else begin
              op_r <= op_r + 1'b1;
              state_r <= S_PERM_RD;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        S_EMIT_REP: begin
          hold_pat_r <= rep_r;
          hold_rep_r <= 1'b1;
          k_r <= '0;
          emitted_r <= 5'd1;
          state_r <= S_EMIT_MEM;
        end
        S_EMIT_MEM: begin
          // one result is held back until it is known whether it is the last
          if (emit_end || !mem_skip) begin
            out_strobe <= 1'b1;
            out_item.orbit_number <= orbit_r;
            out_item.pattern <= hold_pat_r;
            out_item.image_count <= cnt_r;
            out_item.is_representative <= hold_rep_r;
            out_item.done_res <= 1'b0;
            out_item.last <= emit_end;
          end
          if (emit_end) begin
            state_r <= S_IDLE;
          end else begin
            k_r <= k_r + 1'b1;
            if (!mem_skip) begin
              hold_pat_r <= members_r[k_r];
              hold_rep_r <= 1'b0;
              emitted_r <= emitted_r + 1'b1;
            end
          end
        end
        S_DONE: begin
          out_strobe <= 1'b1;
          out_item.orbit_number <= orbit_r;
          out_item.pattern <= '0;
          out_item.image_count <= '0;
          out_item.is_representative <= 1'b0;
          out_item.done_res <= 1'b1;
          out_item.last <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 5'(MAX_OPS));
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> (state_r == S_IDLE));
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.done_res) |-> out_item.last);
  a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !$isunknown(out_item));
endmodule

>>> hw/rtl/bpoe_ram.sv
`timescale 1ns / 1ps
module bpoe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> test/orbit_checker.sv
`timescale 1ns / 1ps
module orbit_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  bpoe_pkg::in_item_t  in_item,
  input  logic                out_strobe,
  input  bpoe_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [4:0]          cfg_index,
  input  logic [4:0]          cfg_data,
  output int                  mismatches,
  output int                  pending
);
  import bpoe_pkg::*;

  bit          visited [0:MAP_DEPTH-1];
  logic [4:0]  perm_tab [0:PERM_DEPTH-1];
  int          scan_ptr;
  logic [18:0] orbit_cnt;
  logic [4:0]  atoms_reg;
  logic [4:0]  ops_reg;
  out_item_t   expected_results[$];

  assign pending = expected_results.size();

  task automatic report(string field, int got, int want);
    $display("mismatch at %0t in %s: got %0h expected %0h", $realtime, field, got, want);
    mismatches++;
  endtask

  task automatic enumerate_next_orbit();
    int n, lim, ops, rep, img, cnt;
    int members[$];
    bit seen;
    out_item_t r;
    n = (atoms_reg > MAX_SITES) ? MAX_SITES : atoms_reg;
    lim = 1 << n;
    while (scan_ptr < lim && visited[scan_ptr]) scan_ptr++;
    if (scan_ptr >= lim) begin
      r = '0;
      r.orbit_number = orbit_cnt;
      r.done_res = 1'b1;
      r.last = 1'b1;
      expected_results.push_back(r);
      return;
    end
    rep = scan_ptr;
    scan_ptr++;
    orbit_cnt = orbit_cnt + 19'd1;
    ops = (ops_reg > MAX_OPS) ? MAX_OPS : ops_reg;
    for (int v = 0; v < ops; v++) begin
      img = 0;
      for (int i = 0; i < n; i++)
        if (rep[i] && perm_tab[v * MAX_SITES + i] < n)
          img |= 1 << perm_tab[v * MAX_SITES + i];
      seen = 0;
      foreach (members[k]) if (members[k] == img) seen = 1;
      if (!seen) begin
        members.push_back(img);
        visited[img] = 1;
      end
    end
    r = '0;
    r.orbit_number = orbit_cnt;
    r.pattern = rep[17:0];
    r.image_count = 5'(members.size());
    r.is_representative = 1'b1;
    expected_results.push_back(r);
    cnt = 1;
    foreach (members[k]) begin
      if (cnt < MAX_OPS && members[k] != rep) begin
        r.pattern = members[k][17:0];
        r.is_representative = 1'b0;
        expected_results.push_back(r);
        cnt++;
      end
    end
    expected_results[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      foreach (visited[i]) visited[i] = 0;
      foreach (perm_tab[i]) perm_tab[i] = '0;
      scan_ptr = 0;
      orbit_cnt = '0;
      atoms_reg = 5'd18;
      ops_reg = 5'd0;
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == 5'(CFG_ATOM_COUNT)) atoms_reg = cfg_data;
        else if (cfg_index == 5'(CFG_GROUP_ORDER)) ops_reg = cfg_data;
      end
      if (start && !busy) begin
        case (in_item.req_type)
          REQ_LOAD: begin
            if (in_item.op_slot < MAX_OPS && in_item.source_site < MAX_SITES)
              perm_tab[in_item.op_slot * MAX_SITES + in_item.source_site] =
                in_item.dest_site;
          end
          REQ_RESTART: begin
            foreach (visited[i]) visited[i] = 0;
            scan_ptr = 0;
            orbit_cnt = '0;
          end
          REQ_NEXT: enumerate_next_orbit();
          default: ;
        endcase
      end
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          report("unexpected result", out_item.pattern, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.orbit_number !== want.orbit_number)
            report("orbit_number", out_item.orbit_number, want.orbit_number);
          if (out_item.pattern !== want.pattern)
            report("pattern", out_item.pattern, want.pattern);
          if (out_item.image_count !== want.image_count)
            report("image_count", out_item.image_count, want.image_count);
          if (out_item.is_representative !== want.is_representative)
            report("is_representative", out_item.is_representative,
                   want.is_representative);
          if (out_item.done_res !== want.done_res)
            report("done_res", out_item.done_res, want.done_res);
          if (out_item.last !== want.last)
            report("last", out_item.last, want.last);
        end
      end
    end
  end
endmodule

>>> test/bit_pattern_orbit_enumerator_top_tb.sv
`timescale 1ns / 1ps
module bit_pattern_orbit_enumerator_top_tb;
  import bpoe_pkg::*;

  logic      clk = 0;
  logic      rst_n = 0;
  logic      start = 0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_strobe;
  out_item_t out_item;
  logic      cfg_valid = 0;
  logic      cfg_ready;
  logic [4:0] cfg_index = '0;
  logic [4:0] cfg_data = '0;
  int        mismatches;
  int        pending;

  int idle_pct;
  int eff_atoms;
  int eff_ops;
  bit written [0:PERM_DEPTH-1];

  bit_pattern_orbit_enumerator_top i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  orbit_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("FAIL");
    $finish;
  end

  function automatic in_item_t mk(logic [1:0] req, int slot, int src, int dst);
    in_item_t it;
    it.req_type = req;
    it.op_slot = 5'(slot);
    it.source_site = 5'(src);
    it.dest_site = 5'(dst);
    return it;
  endfunction

  task automatic send(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    if (it.req_type == REQ_LOAD && it.op_slot < MAX_OPS && it.source_site < MAX_SITES)
      written[it.op_slot * MAX_SITES + it.source_site] = 1;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after its last write
  task automatic write_cfg(logic [4:0] idx, logic [4:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == 5'(CFG_ATOM_COUNT)) eff_atoms = (val > MAX_SITES) ? MAX_SITES : val;
    else eff_ops = (val > MAX_OPS) ? MAX_OPS : val;
  endtask

  task automatic setup(int atoms, int ops, int idle);
    wait_idle();
    write_cfg(5'(CFG_ATOM_COUNT), 5'(atoms));
    write_cfg(5'(CFG_GROUP_ORDER), 5'(ops));
    cfg_valid <= 1'b0;
    idle_pct = idle;
  endtask

  // a next request goes out only once every table entry it could read is loaded
  task automatic random_request();
    int r, hi, miss;
    r = $urandom_range(99);
    hi = (eff_atoms > 0) ? eff_atoms - 1 : 0;
    if (r < 5) begin
      send(mk(REQ_RESERVED, $urandom_range(31), $urandom_range(31), $urandom_range(31)));
    end else if (r < 35) begin
      send(mk(REQ_LOAD,
              $urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(MAX_OPS - 1),
              $urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(hi),
              $urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(hi)));
    end else begin
      miss = -1;
      for (int s = 0; s < eff_ops && miss < 0; s++)
        for (int i = 0; i < eff_atoms && miss < 0; i++)
          if (!written[s * MAX_SITES + i]) miss = s * MAX_SITES + i;
      if (miss >= 0)
        send(mk(REQ_LOAD, miss / MAX_SITES, miss % MAX_SITES, $urandom_range(hi)));
      else
        send(mk(REQ_NEXT, $urandom_range(31), $urandom_range(31), $urandom_range(31)));
    end
  endtask

  int phase_atoms [7] = '{4, 3, 6, 31, 0, 1, 10};
  int phase_ops   [7] = '{3, 24, 31, 2, 5, 24, 4};
  int phase_idle  [7] = '{0, 85, 6, 0, 85, 6, 0};
  int phase_len   [7] = '{40, 50, 50, 40, 30, 30, 60};

  initial begin
    eff_atoms = MAX_SITES;
    eff_ops = 0;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty group: every pattern is its own orbit of size zero, then done
    setup(3, 0, 0);
    send(mk(REQ_RESERVED, 31, 31, 31));
    send(mk(REQ_LOAD, 31, 0, 0));
    send(mk(REQ_LOAD, 0, 31, 0));
    repeat (9) send(mk(REQ_NEXT, 0, 0, 0));
    send(mk(REQ_RESTART, 0, 0, 0));
    // identity, a rotation, and a map whose destination leaves the pattern
    for (int i = 0; i < 3; i++) send(mk(REQ_LOAD, 0, i, i));
    for (int i = 0; i < 3; i++) send(mk(REQ_LOAD, 1, i, (i + 1) % 3));
    send(mk(REQ_LOAD, 2, 0, 31));
    send(mk(REQ_LOAD, 2, 1, 1));
    send(mk(REQ_LOAD, 2, 2, 2));
    setup(3, 3, 0);
    repeat (6) send(mk(REQ_NEXT, 0, 0, 0));

    for (int p = 0; p < 7; p++) begin
      setup(phase_atoms[p], phase_ops[p], phase_idle[p]);
      repeat (phase_len[p]) random_request();
    end

    wait_idle();
    if (mismatches == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

>>> filelist.f
hw/rtl/bpoe_pkg.sv
hw/rtl/bpoe_ram.sv
hw/rtl/bit_pattern_orbit_enumerator_top.sv
test/orbit_checker.sv
test/bit_pattern_orbit_enumerator_top_tb.sv
